// ===== rtl/core/spl_pkg.sv =====
// shared types, codes and constants of the priority list engine
`default_nettype none

package spl_pkg;

	localparam int SPL_DEPTH = 16;
	localparam int OUT_LIMIT = 16;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_SEARCH = 2'd2;
	localparam logic [1:0] OP_LIST   = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOTFOUND = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] entry_key;
		logic [2:0]  prio_level;
		logic [15:0] payload;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] out_key;
		logic [2:0]  out_prio;
		logic [15:0] out_payload;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic [15:0] key;
		logic [2:0]  prio;
		logic [15:0] payload;
	} entry_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		entry_t ent;
		logic   do_insert;
		logic   do_remove;
		logic   rd_tok;
		logic   tok_shift;
		logic   tok_clr;
	} cell_cmd_t;

	typedef enum logic {
		S_IDLE,
		S_LIST
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/core/spl_cell.sv =====
// one slot of the sorted table with its compare, shift and list token logic
`default_nettype none

module spl_cell
	import spl_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_cmd_t cmd,
	input  logic      occ,
	input  logic      prev_ge,
	input  logic      prev_found,
	input  logic      prev_tok,
	input  entry_t    prev_data,
	input  entry_t    next_data,
	output logic      ge,
	output logic      found,
	output logic      tok,
	output entry_t    data,
	output entry_t    rd_data
);

	entry_t data_q;
	logic   tok_q;
	logic   match;
	logic   hit;

	always_comb begin
		match = occ && (data_q.key == cmd.ent.key);
		found = prev_found | match;
		hit   = match & ~prev_found;
		// new entry belongs at or before this slot
		ge    = ~occ | (data_q.prio > cmd.ent.prio);
	end

	assign rd_data = (cmd.rd_tok ? tok_q : hit) ? data_q : '0;
	assign data    = data_q;
	assign tok     = tok_q;

	always_ff @(posedge clk) begin
		if (cmd.do_insert && ge) begin
			data_q <= prev_ge ? prev_data : cmd.ent;
		end else if (cmd.do_remove && found) begin
			data_q <= next_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else if (cmd.tok_clr) begin
			tok_q <= 1'b0;
		end else if (cmd.tok_shift) begin
			tok_q <= prev_tok;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/stable_priority_list_engine_core.sv =====
// Sorted priority table: DEPTH slots ordered by priority, equal priorities in arrival order.
// Requests come on req (valid/stall): insert, remove by key, search by key, list all.
// Results leave on rsp (valid/stall) from one output register; each carries a status and
// last marks the final result of a request.
// Insert, remove and search finish in the cycle they are accepted: every slot compares in
// parallel and shifts one place toward or away from its neighbor, so the result shows on
// rsp the next cycle and such requests can be taken every cycle while rsp keeps flowing.
// List walks a one-hot token down the row of slots, one entry per cycle while rsp is not
// stalled; it emits min(fill, 16) entries, with req stalled meanwhile.
// A request is taken only when the output register is empty or being drained in the same
// cycle, so a stall on rsp holds the pending result and back-pressures req.
// Reset clears the fill count, the list token and the state; slot contents are not cleared
// and only occupied slots are ever reported. No clearing pass follows reset.
`default_nettype none

module stable_priority_list_engine_core
	import spl_pkg::*;
#(
	parameter int DEPTH = SPL_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int FillW   = $clog2(DEPTH + 1);
	localparam int IdxW    = $clog2(DEPTH);
	localparam int ListMax = (DEPTH < OUT_LIMIT) ? DEPTH : OUT_LIMIT;

	state_t            state_q, state_d;
	logic [FillW-1:0]  fill_q, fill_d;
	logic [IdxW-1:0]   cnt_q, cnt_d;
	logic [IdxW-1:0]   last_idx_q, last_idx_d;
	rsp_t              rsp_q, rsp_d;
	logic              rsp_valid_q;
	logic              rsp_load;
	cell_cmd_t         cmd;
	logic              tok_head;
	logic              full, empty, free, acc;
	logic [FillW-1:0]  list_n, list_m1;

	logic [DEPTH-1:0]  ge_v;
	logic [DEPTH-1:0]  found_v;
	logic [DEPTH-1:0]  tok_v;
	logic [DEPTH-1:0]  occ_v;
	entry_t            data_v [DEPTH];
	entry_t            rd_v [DEPTH];
	entry_t            rd_any;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic   prev_ge;
		logic   prev_found;
		logic   prev_tok;
		entry_t prev_data;
		entry_t next_data;

		if (i == 0) begin : g_head
			assign prev_ge    = 1'b0;
			assign prev_found = 1'b0;
			assign prev_tok   = tok_head;
			assign prev_data  = '0;
		end else begin : g_body
			assign prev_ge    = ge_v[i-1];
			assign prev_found = found_v[i-1];
			assign prev_tok   = tok_v[i-1];
			assign prev_data  = data_v[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign next_data = '0;
		end else begin : g_inner
			assign next_data = data_v[i+1];
		end

		assign occ_v[i] = (FillW'(i) < fill_q);

		spl_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.occ       (occ_v[i]),
			.prev_ge   (prev_ge),
			.prev_found(prev_found),
			.prev_tok  (prev_tok),
			.prev_data (prev_data),
			.next_data (next_data),
			.ge        (ge_v[i]),
			.found     (found_v[i]),
			.tok       (tok_v[i]),
			.data      (data_v[i]),
			.rd_data   (rd_v[i])
		);
	end

	// at most one cell drives a nonzero read value
	always_comb begin
		rd_any = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_any = rd_any | rd_v[i];
		end
	end

	assign full      = (fill_q == FillW'(DEPTH));
	assign empty     = (fill_q == '0);
	assign free      = ~rsp_valid_q | ~rsp_stall;
	assign req_stall = (state_q != S_IDLE) | ~free;
	assign acc       = req_valid & ~req_stall;
	assign list_n    = (fill_q > FillW'(ListMax)) ? FillW'(ListMax) : fill_q;
	assign list_m1   = list_n - FillW'(1);

	always_comb begin
		state_d       = state_q;
		fill_d        = fill_q;
		cnt_d         = cnt_q;
		last_idx_d    = last_idx_q;
		rsp_d         = rsp_q;
		rsp_load      = 1'b0;
		tok_head      = 1'b0;
		cmd           = '0;
		cmd.ent       = '{key: req.entry_key, prio: req.prio_level, payload: req.payload};
		cmd.rd_tok    = (state_q == S_LIST);

		case (state_q)
			S_IDLE: begin
				if (acc) begin
					rsp_load    = 1'b1;
					rsp_d       = '0;
					rsp_d.last  = 1'b1;
					rsp_d.status = ST_OK;
					case (req.opcode)
						OP_INSERT: begin
							if (full) begin
								rsp_d.status = ST_FULL;
							end else begin
								cmd.do_insert = 1'b1;
								fill_d        = fill_q + FillW'(1);
							end
						end
						OP_REMOVE: begin
							if (empty) begin
								rsp_d.status = ST_EMPTY;
							end else if (!found_v[DEPTH-1]) begin
								rsp_d.status = ST_NOTFOUND;
							end else begin
								cmd.do_remove = 1'b1;
								fill_d        = fill_q - FillW'(1);
							end
						end
						OP_SEARCH: begin
							if (empty) begin
								rsp_d.status = ST_EMPTY;
							end else if (!found_v[DEPTH-1]) begin
								rsp_d.status = ST_NOTFOUND;
							end else begin
								rsp_d.out_key     = rd_any.key;
								rsp_d.out_prio    = rd_any.prio;
								rsp_d.out_payload = rd_any.payload;
							end
						end
						OP_LIST: begin
							if (empty) begin
								rsp_d.status = ST_EMPTY;
							end else begin
								// no result yet: load the token into the head slot
								rsp_load      = 1'b0;
								tok_head      = 1'b1;
								cmd.tok_shift = 1'b1;
								cnt_d         = '0;
								last_idx_d    = list_m1[IdxW-1:0];
								state_d       = S_LIST;
							end
						end
						default: begin
							rsp_d.status = ST_OK;
						end
					endcase
				end
			end
			S_LIST: begin
				if (free) begin
					rsp_load          = 1'b1;
					rsp_d.status      = ST_OK;
					rsp_d.out_key     = rd_any.key;
					rsp_d.out_prio    = rd_any.prio;
					rsp_d.out_payload = rd_any.payload;
					rsp_d.last        = (cnt_q == last_idx_q);
					if (cnt_q == last_idx_q) begin
						cmd.tok_clr = 1'b1;
						state_d     = S_IDLE;
					end else begin
						cmd.tok_shift = 1'b1;
						cnt_d         = cnt_q + IdxW'(1);
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			cnt_q       <= '0;
			last_idx_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			fill_q     <= fill_d;
			cnt_q      <= cnt_d;
			last_idx_q <= last_idx_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FillW'(DEPTH))
		else $error("fill count above table depth");

	a_tok_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LIST) |-> $onehot(tok_v))
		else $error("list token lost or duplicated");

	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && req.opcode == OP_INSERT && full) |=> $stable(fill_q))
		else $error("insert into full table changed fill count");

	a_last_only_list: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.last) |-> (state_q == S_LIST))
		else $error("non-final transfer outside a list walk");
`endif

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the stable priority list engine with random idling on both channels

module testbench;
	import spl_pkg::*;

	localparam int IDLE_LIMIT = 1000;
	localparam int CALM_TAIL  = 20;

	typedef struct {
		req_t r;
		bit   hold;
	} pend_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	pend_t pending[$];
	rsp_t  expected_rsp[$];

	// shadow of the table
	entry_t      shadow_tbl [SPL_DEPTH];
	int unsigned shadow_fill = 0;

	int  mismatches = 0;
	bit  req_taken = 1'b0;
	bit  calm = 1'b0;
	int  gap_left = 0;
	int  stall_left = 0;
	int  idle_cycles = 0;
	logic [15:0] key_pool [16];

	stable_priority_list_engine_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic rsp_t make_rsp(logic [1:0] st, entry_t e, logic lst);
		rsp_t o;
		o.status      = st;
		o.out_key     = e.key;
		o.out_prio    = e.prio;
		o.out_payload = e.payload;
		o.last        = lst;
		return o;
	endfunction

	// table update and expected results for one accepted request
	function automatic void predict_table(req_t r);
		int     pos;
		int     idx;
		int     n;
		entry_t blank;
		blank = '0;
		idx = -1;
		case (r.opcode)
			OP_INSERT: begin
				if (shadow_fill >= SPL_DEPTH) begin
					expected_rsp.push_back(make_rsp(ST_FULL, blank, 1'b1));
				end else begin
					pos = 0;
					while (pos < shadow_fill && shadow_tbl[pos].prio <= r.prio_level)
						pos++;
					for (int i = shadow_fill; i > pos; i--)
						shadow_tbl[i] = shadow_tbl[i - 1];
					shadow_tbl[pos].key     = r.entry_key;
					shadow_tbl[pos].prio    = r.prio_level;
					shadow_tbl[pos].payload = r.payload;
					shadow_fill++;
					expected_rsp.push_back(make_rsp(ST_OK, blank, 1'b1));
				end
			end
			OP_REMOVE, OP_SEARCH: begin
				for (int i = 0; i < shadow_fill; i++)
					if (idx < 0 && shadow_tbl[i].key == r.entry_key)
						idx = i;
				if (shadow_fill == 0) begin
					expected_rsp.push_back(make_rsp(ST_EMPTY, blank, 1'b1));
				end else if (idx < 0) begin
					expected_rsp.push_back(make_rsp(ST_NOTFOUND, blank, 1'b1));
				end else if (r.opcode == OP_SEARCH) begin
					expected_rsp.push_back(make_rsp(ST_OK, shadow_tbl[idx], 1'b1));
				end else begin
					for (int i = idx; i + 1 < shadow_fill; i++)
						shadow_tbl[i] = shadow_tbl[i + 1];
					shadow_fill--;
					expected_rsp.push_back(make_rsp(ST_OK, blank, 1'b1));
				end
			end
			default: begin
				if (shadow_fill == 0) begin
					expected_rsp.push_back(make_rsp(ST_EMPTY, blank, 1'b1));
				end else begin
					n = (shadow_fill > OUT_LIMIT) ? OUT_LIMIT : shadow_fill;
					for (int i = 0; i < n; i++)
						expected_rsp.push_back(make_rsp(ST_OK, shadow_tbl[i], i + 1 == n));
				end
			end
		endcase
	endfunction

	task automatic note_mismatch(string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic check_result(rsp_t got, rsp_t want);
		if (got.status !== want.status)
			note_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
		if (got.out_key !== want.out_key)
			note_mismatch($sformatf("out_key %h, want %h", got.out_key, want.out_key));
		if (got.out_prio !== want.out_prio)
			note_mismatch($sformatf("out_prio %0d, want %0d", got.out_prio, want.out_prio));
		if (got.out_payload !== want.out_payload)
			note_mismatch($sformatf("out_payload %h, want %h", got.out_payload,
				want.out_payload));
		if (got.last !== want.last)
			note_mismatch($sformatf("last %0d, want %0d", got.last, want.last));
	endtask

	task automatic add_item(logic [1:0] op, logic [15:0] k, logic [2:0] p, logic [15:0] d,
			bit hold = 1'b0);
		pend_t it;
		it.r.opcode     = op;
		it.r.entry_key  = k;
		it.r.prio_level = p;
		it.r.payload    = d;
		it.hold         = hold;
		pending.push_back(it);
	endtask

	function automatic logic [15:0] pick_key();
		if ($urandom_range(0, 99) < 80)
			return key_pool[$urandom_range(0, 15)];
		return 16'($urandom);
	endfunction

	// request driver
	always @(negedge clk) begin : drive
		logic  nv;
		req_t  np;
		pend_t it;
		nv = req_valid;
		np = req;
		if (arst_n) begin
			if (req_valid && req_taken)
				nv = 1'b0;
			if (!nv) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending.size() != 0 &&
						!(pending[0].hold && expected_rsp.size() != 0)) begin
					if (!calm && $urandom_range(0, 5) == 0) begin
						gap_left = $urandom_range(1, 8) - 1;
					end else begin
						it = pending.pop_front();
						np = it.r;
						nv = 1'b1;
					end
				end
			end
		end
		req_valid <= nv;
		req <= np;
	end

	// result-side back-pressure
	always @(negedge clk) begin : stall_gen
		if (stall_left > 0) begin
			stall_left--;
			rsp_stall <= 1'b1;
		end else if (!calm && arst_n && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 8) - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// result checker and request predictor; results first, then the new request
	always @(posedge clk) begin : monitor
		rsp_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsp.size() == 0) begin
					note_mismatch($sformatf("result with nothing pending, status %0d",
						rsp.status));
				end else begin
					want = expected_rsp.pop_front();
					check_result(rsp, want);
				end
			end
			if (req_valid && !req_stall)
				predict_table(req);
			req_taken <= req_valid && !req_stall;
			calm <= (pending.size() <= CALM_TAIL);
		end
	end

	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int pick;
		key_pool[0] = 16'h0000;
		key_pool[1] = 16'hFFFF;
		for (int i = 2; i < 16; i++)
			key_pool[i] = 16'($urandom);

		// empty table cases
		add_item(OP_LIST,   16'h0000, 3'd0, 16'h0000);
		add_item(OP_REMOVE, 16'hFFFF, 3'd7, 16'hFFFF);
		add_item(OP_SEARCH, 16'h0000, 3'd0, 16'h0000);
		// field extremes, equal priorities in arrival order, duplicate keys
		add_item(OP_INSERT, 16'hFFFF, 3'd7, 16'hFFFF);
		add_item(OP_INSERT, 16'h0000, 3'd0, 16'h0000);
		add_item(OP_INSERT, 16'h1234, 3'd3, 16'hAAAA);
		add_item(OP_INSERT, 16'h1234, 3'd3, 16'h5555);
		add_item(OP_INSERT, 16'h0001, 3'd3, 16'h0F0F);
		add_item(OP_INSERT, 16'h8000, 3'd0, 16'h8001);
		add_item(OP_SEARCH, 16'h1234, 3'd5, 16'h3C3C);
		add_item(OP_SEARCH, 16'h4321, 3'd2, 16'hC3C3);
		add_item(OP_LIST,   16'h7FFF, 3'd7, 16'h7FFF);
		add_item(OP_REMOVE, 16'h1234, 3'd0, 16'h0000);
		add_item(OP_SEARCH, 16'h1234, 3'd0, 16'h0000);
		add_item(OP_REMOVE, 16'h9999, 3'd1, 16'h0000);
		add_item(OP_REMOVE, 16'hFFFF, 3'd4, 16'h0000);
		// sender waits for the table to go quiet here
		add_item(OP_LIST,   16'h0000, 3'd0, 16'h0000, 1'b1);

		// fill until full, then hammer the full table
		for (int i = 0; i < 40; i++) begin
			pick = $urandom_range(0, 99);
			add_item(pick < 85 ? OP_INSERT : (pick < 93 ? OP_LIST : OP_SEARCH),
				pick_key(), 3'($urandom), 16'($urandom));
		end
		add_item(OP_LIST, pick_key(), 3'($urandom), 16'($urandom));
		// mixed traffic
		for (int i = 0; i < 26; i++) begin
			pick = $urandom_range(0, 99);
			add_item(pick < 40 ? OP_INSERT : (pick < 65 ? OP_REMOVE :
				(pick < 85 ? OP_SEARCH : OP_LIST)),
				pick_key(), 3'($urandom), 16'($urandom));
		end
		// drain
		for (int i = 0; i < 26; i++) begin
			pick = $urandom_range(0, 99);
			add_item(pick < 65 ? OP_REMOVE : (pick < 80 ? OP_SEARCH :
				(pick < 90 ? OP_LIST : OP_INSERT)),
				pick_key(), 3'($urandom), 16'($urandom));
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending.size() != 0 || req_valid)
			@(posedge clk);
		while (expected_rsp.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (mismatches == 0 && expected_rsp.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/spl_pkg.sv
rtl/core/spl_cell.sv
rtl/core/stable_priority_list_engine_core.sv
tb/testbench.sv
